/* rtl/core/suf_pkg.sv */
// Shared types, widths and state encoding for the spanning forest union-find unit.
`default_nettype none

package suf_pkg;

   localparam int NODES_DEFAULT = 1024;
   localparam int NODE_W        = 10;
   localparam int WEIGHT_W      = 32;
   localparam int SUM_W         = 48;
   localparam int RANK_W        = 4;

   localparam logic [RANK_W-1:0] RANK_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

   typedef struct packed {
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic [WEIGHT_W-1:0] weight;
      logic                first_edge;
   } req_word_type;

   typedef struct packed {
      logic             accepted;
      logic [SUM_W-1:0] forest_sum;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_FIND_A,
      ST_COMP_A,
      ST_FIND_B,
      ST_COMP_B,
      ST_LINK,
      ST_BUMP
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/suf_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module suf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/spanning_forest_union_find_unit.sv */
// Top level of the spanning forest union-find unit: edge acceptance on a disjoint-set forest.
//
//   port group   direction  handshake                 word
//   req_         in         start high, busy low      req_word_type (edge)
//   rsp_         out        rsp_strobe, one cycle     rsp_word_type (accept flag, sum)
//
// An edge makes one parent memory read per step of each root walk and of each
// compression pass; a tie in rank below RANK_MAX adds a rank update of the new root.
// After reset, and before any edge that starts a new graph, a clearing pass
// writes every entry once, with busy held high.
// Results cannot be stalled; each one is shown for exactly one cycle.
`default_nettype none

module spanning_forest_union_find_unit
   import suf_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int EW = AW + RANK_W;
   localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);

   state_type state_ff, state_in;

   req_word_type      edge_ff, edge_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     root_a_ff, root_a_in;
   logic [AW-1:0]     root_b_ff, root_b_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic              pend_ff, pend_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [EW-1:0]     fwd_data_ff, fwd_data_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [EW-1:0]     mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [EW-1:0]     mem_rdata;

   logic [EW-1:0]     rd_data;
   logic [AW-1:0]     rd_par;
   logic [RANK_W-1:0] rd_rank;
   logic [AW-1:0]     addr_a;
   logic [AW-1:0]     addr_b;
   logic              in_range;
   logic              same_root;
   logic              bump;
   logic [SUM_W:0]    sum_add;

   suf_ram #(
      .WIDTH (EW),
      .DEPTH (NODES)
   ) u_forest_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // A read of the entry written in the same cycle takes the written value.
   assign fwd_hit_in  = mem_we && (mem_waddr == mem_raddr);
   assign fwd_data_in = mem_wdata;
   assign rd_data     = fwd_hit_ff ? fwd_data_ff : mem_rdata;
   assign rd_par      = rd_data[EW-1:RANK_W];
   assign rd_rank     = rd_data[RANK_W-1:0];

   assign addr_a    = AW'(edge_ff.node_a);
   assign addr_b    = AW'(edge_ff.node_b);
   assign in_range  = (32'(edge_ff.node_a) < 32'(NODES)) &&
                      (32'(edge_ff.node_b) < 32'(NODES));
   assign same_root = (root_a_ff == root_b_ff);
   assign bump      = !same_root && (rank_a_ff == rank_b_ff) && (rank_a_ff != RANK_MAX);
   assign sum_add   = {1'b0, sum_ff} + (SUM_W + 1)'(edge_ff.weight);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_NODE) begin
               state_in = pend_ff ? ST_CHECK : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = req_word.first_edge ? ST_CLEAR : ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = in_range ? ST_FIND_A : ST_IDLE;
         end
         ST_FIND_A: begin
            if (rd_par == cur_ff) begin
               state_in = (addr_a == cur_ff) ? ST_FIND_B : ST_COMP_A;
            end
         end
         ST_COMP_A: begin
            if (rd_par == root_a_ff) begin
               state_in = ST_FIND_B;
            end
         end
         ST_FIND_B: begin
            if (rd_par == cur_ff) begin
               state_in = (addr_b == cur_ff) ? ST_LINK : ST_COMP_B;
            end
         end
         ST_COMP_B: begin
            if (rd_par == root_b_ff) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            state_in = bump ? ST_BUMP : ST_IDLE;
         end
         ST_BUMP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_we          = 1'b0;
      mem_waddr       = cur_ff;
      mem_wdata       = {cur_ff, rd_rank};
      mem_raddr       = cur_ff;
      edge_in         = edge_ff;
      cur_in          = cur_ff;
      root_a_in       = root_a_ff;
      root_b_in       = root_b_ff;
      rank_a_in       = rank_a_ff;
      rank_b_in       = rank_b_ff;
      clr_cnt_in      = clr_cnt_ff;
      pend_in         = pend_ff;
      sum_in          = sum_ff;
      rsp_strobe_in   = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = {clr_cnt_ff, {RANK_W{1'b0}}};
            if (clr_cnt_ff == LAST_NODE) begin
               clr_cnt_in = '0;
               pend_in    = 1'b0;
            end else begin
               clr_cnt_in = clr_cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               edge_in = req_word;
               if (req_word.first_edge) begin
                  sum_in     = '0;
                  pend_in    = 1'b1;
                  clr_cnt_in = '0;
               end
            end
         end
         ST_CHECK: begin
            mem_raddr = addr_a;
            cur_in    = addr_a;
            if (!in_range) begin
               rsp_strobe_in   = 1'b1;
               rsp_accepted_in = 1'b0;
            end
         end
         ST_FIND_A: begin
            if (rd_par == cur_ff) begin
               root_a_in = cur_ff;
               rank_a_in = rd_rank;
               if (addr_a == cur_ff) begin
                  mem_raddr = addr_b;
                  cur_in    = addr_b;
               end else begin
                  mem_raddr = addr_a;
                  cur_in    = addr_a;
               end
            end else begin
               mem_raddr = rd_par;
               cur_in    = rd_par;
            end
         end
         ST_COMP_A: begin
            mem_we    = 1'b1;
            mem_wdata = {root_a_ff, rd_rank};
            if (rd_par == root_a_ff) begin
               mem_raddr = addr_b;
               cur_in    = addr_b;
            end else begin
               mem_raddr = rd_par;
               cur_in    = rd_par;
            end
         end
         ST_FIND_B: begin
            if (rd_par == cur_ff) begin
               root_b_in = cur_ff;
               rank_b_in = rd_rank;
               mem_raddr = addr_b;
               cur_in    = addr_b;
            end else begin
               mem_raddr = rd_par;
               cur_in    = rd_par;
            end
         end
         ST_COMP_B: begin
            mem_we    = 1'b1;
            mem_wdata = {root_b_ff, rd_rank};
            mem_raddr = rd_par;
            cur_in    = rd_par;
         end
         ST_LINK: begin
            rsp_strobe_in   = 1'b1;
            rsp_accepted_in = !same_root;
            if (!same_root) begin
               mem_we = 1'b1;
               if (rank_a_ff < rank_b_ff) begin
                  mem_waddr = root_a_ff;
                  mem_wdata = {root_b_ff, rank_a_ff};
               end else begin
                  mem_waddr = root_b_ff;
                  mem_wdata = {root_a_ff, rank_b_ff};
               end
               sum_in = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
         end
         ST_BUMP: begin
            mem_we    = 1'b1;
            mem_waddr = root_a_ff;
            mem_wdata = {root_a_ff, rank_a_ff + RANK_W'(1)};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         pend_ff       <= 1'b0;
         sum_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         pend_ff       <= pend_in;
         sum_ff        <= sum_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff         <= edge_in;
      cur_ff          <= cur_in;
      root_a_ff       <= root_a_in;
      root_b_ff       <= root_b_in;
      rank_a_ff       <= rank_a_in;
      rank_b_ff       <= rank_b_in;
      rsp_accepted_ff <= rsp_accepted_in;
      fwd_data_ff     <= fwd_data_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_word.accepted   = rsp_accepted_ff;
   assign rsp_word.forest_sum = sum_ff;

endmodule

`default_nettype wire

/* rtl/core/suf_checker.sv */
// Port-level checker for the spanning forest union-find unit, bound to the top level.
`default_nettype none

module suf_checker
   import suf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_word_type req_word,
   input logic         rsp_strobe,
   input rsp_word_type rsp_word
);

   // Every edge needs at least a range check before its result, so results never abut.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result words in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted edge did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.first_edge) |=> busy ##1 busy)
      else $error("new graph did not hold busy through the clearing pass");

   // A result always closes work that kept the unit busy in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without preceding work");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.accepted) |-> $stable(rsp_word.forest_sum))
      else $error("rejected edge changed the running sum");

endmodule

bind spanning_forest_union_find_unit suf_checker u_suf_checker (.*);

`default_nettype wire
